// ===== sv/pad_pkg.sv =====
// Shared types and constants for the point-at-distance-along-line core.
`timescale 1ns / 1ps
package pad_pkg;

  localparam int THR_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd256;
  localparam int Q_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_ALONG_X = 2'd1,
    KIND_ALONG_Y = 2'd2,
    KIND_BOTH    = 2'd3
  } pad_kind_t;

  typedef struct packed {
    pad_kind_t kind;
    logic      mode;
    logic      neg_x;
    logic      neg_y;
  } pad_ctl_t;

  localparam int CTL_W = $bits(pad_ctl_t);

endpackage

// ===== sv/pad_front.sv =====
// Front end: request acceptance, snap threshold register and direction classification.
`timescale 1ns / 1ps
module pad_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_mode,
  input  logic signed [COORD_WIDTH-1:0]  in_start_x,
  input  logic signed [COORD_WIDTH-1:0]  in_start_y,
  input  logic signed [COORD_WIDTH-1:0]  in_toward_x,
  input  logic signed [COORD_WIDTH-1:0]  in_toward_y,
  input  logic [COORD_WIDTH-2:0]         in_step_length,
  input  logic                           cfg_wr_en,
  input  logic [pad_pkg::THR_W-1:0]      cfg_wr_data,
  input  logic                           q_ready,
  output logic                           f_vld,
  output pad_pkg::pad_ctl_t              f_ctl,
  output logic [COORD_WIDTH-1:0]         f_x0,
  output logic [COORD_WIDTH-1:0]         f_y0,
  output logic [COORD_WIDTH-1:0]         f_adx,
  output logic [COORD_WIDTH-1:0]         f_ady,
  output logic [COORD_WIDTH-2:0]         f_dist
);
  import pad_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int CMPW = (W > THR_W) ? W : THR_W;

  logic [THR_W-1:0] thr_r;
  logic             vld_r;
  pad_ctl_t         ctl_r, ctl_nxt;
  logic [W-1:0]     x0_r, y0_r, adx_r, ady_r, adx_nxt, ady_nxt;
  logic [W-2:0]     dist_r;

  logic             accept;
  logic [W:0]       dx, dy, mx, my;
  logic             snap_x, snap_y, both_zero;

  assign busy   = vld_r && !q_ready;
  assign accept = start && !busy;

  always_comb begin
    dx        = {in_toward_x[W-1], in_toward_x} - {in_start_x[W-1], in_start_x};
    dy        = {in_toward_y[W-1], in_toward_y} - {in_start_y[W-1], in_start_y};
    mx        = dx[W] ? (~dx + (W+1)'(1)) : dx;
    my        = dy[W] ? (~dy + (W+1)'(1)) : dy;
    adx_nxt   = mx[W-1:0];
    ady_nxt   = my[W-1:0];
    snap_x    = CMPW'(adx_nxt) < CMPW'(thr_r);
    snap_y    = CMPW'(ady_nxt) < CMPW'(thr_r);
    both_zero = (adx_nxt == '0) && (ady_nxt == '0);
    ctl_nxt.mode  = in_mode;
    ctl_nxt.neg_x = dx[W];
    ctl_nxt.neg_y = dy[W];
    priority if ((snap_x && snap_y) || both_zero) begin
      ctl_nxt.kind = KIND_NONE;
    end else if (snap_x) begin
      ctl_nxt.kind = KIND_ALONG_Y;
    end else if (snap_y) begin
      ctl_nxt.kind = KIND_ALONG_X;
    end else begin
      ctl_nxt.kind = KIND_BOTH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (accept) begin
        vld_r <= 1'b1;
      end else if (q_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r  <= ctl_nxt;
      x0_r   <= in_start_x;
      y0_r   <= in_start_y;
      adx_r  <= adx_nxt;
      ady_r  <= ady_nxt;
      dist_r <= in_step_length;
    end
  end

  assign f_vld  = vld_r;
  assign f_ctl  = ctl_r;
  assign f_x0   = x0_r;
  assign f_y0   = y0_r;
  assign f_adx  = adx_r;
  assign f_ady  = ady_r;
  assign f_dist = dist_r;

endmodule

// ===== sv/pad_queue.sv =====
// Short request queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module pad_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [DATA_W-1:0] in_data,
  output logic              in_ready,
  output logic              out_vld,
  output logic [DATA_W-1:0] out_data
);
  import pad_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [DATA_W-1:0] mem [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_vld_r;
  logic [DATA_W-1:0] out_data_r;
  logic              push, pop;

  assign in_ready = cnt_r != CNT_W'(Q_DEPTH);
  assign push     = in_vld && in_ready;
  assign pop      = cnt_r != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_data;
    end
    if (pop) begin
      out_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      end
      cnt_r     <= CNT_W'(cnt_r + CNT_W'(push) - CNT_W'(pop));
      out_vld_r <= pop;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

endmodule

// ===== sv/pad_back.sv =====
// Back end: squares, pipelined divider, pipelined square root, rounding and saturation.
`timescale 1ns / 1ps
module pad_back #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          b_vld,
  input  pad_pkg::pad_ctl_t             b_ctl,
  input  logic [COORD_WIDTH-1:0]        b_x0,
  input  logic [COORD_WIDTH-1:0]        b_y0,
  input  logic [COORD_WIDTH-1:0]        b_adx,
  input  logic [COORD_WIDTH-1:0]        b_ady,
  input  logic [COORD_WIDTH-2:0]        b_dist,
  output logic                          out_strobe,
  output logic                          out_found,
  output logic signed [COORD_WIDTH-1:0] out_result_x,
  output logic signed [COORD_WIDTH-1:0] out_result_y
);
  import pad_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int W2     = 2 * W;
  localparam int SIDE_W = 3 * W - 1;
  localparam int DIV_N  = W2;
  localparam int SQ_N   = W;
  localparam logic [W:0] KEEP = {(W+1){1'b1}} << FRAC_BITS;
  localparam logic signed [W+1:0] MAXV = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] MINV = {3'b111, {(W-1){1'b0}}};

  // stage 1: products and squares
  logic              v1_r;
  pad_ctl_t          c1_r;
  logic [SIDE_W-1:0] sd1_r;
  logic [W2-2:0]     p1_r [2];
  logic [W2-1:0]     q1_r [2];
  logic [W2-2:0]     px, py;
  logic [W2-1:0]     sqx, sqy;

  // stage 2: sum of squares, partial products of the squared scale
  logic              v2_r;
  pad_ctl_t          c2_r;
  logic [SIDE_W-1:0] sd2_r;
  logic [W2:0]       s2_r;
  logic [W2-3:0]     hh2_r [2];
  logic [W2-2:0]     hl2_r [2];
  logic [W2-1:0]     ll2_r [2];
  logic [W2:0]       s_sum;
  logic [W-2:0]      ph [2];
  logic [W-1:0]      pl [2];
  logic [W2-3:0]     hh [2];
  logic [W2-2:0]     hl [2];
  logic [W2-1:0]     ll [2];

  // divider pipeline, index 0 loaded from stage 2
  logic              dv_r  [DIV_N+1];
  pad_ctl_t          dc_r  [DIV_N+1];
  logic [SIDE_W-1:0] dsd_r [DIV_N+1];
  logic [W2:0]       ds_r  [DIV_N+1];
  logic [W2:0]       drem_r [2][DIV_N+1];
  logic [W2-1:0]     dlo_r  [2][DIV_N+1];
  logic [W2-1:0]     dq_r   [2][DIV_N+1];
  logic [4*W-1:0]    nsq [2];
  logic [W2+1:0]     dtr [2][DIV_N];
  logic              dge [2][DIV_N];

  // square root pipeline
  logic              sv_r  [SQ_N];
  pad_ctl_t          sc_r  [SQ_N];
  logic [SIDE_W-1:0] ssd_r [SQ_N];
  logic [W2-1:0]     sval_r [2][SQ_N];
  logic [W-1:0]      srt_r  [2][SQ_N];
  logic [W+1:0]      srem_r [2][SQ_N];
  logic [W2-1:0]     si_val [2][SQ_N];
  logic [W-1:0]      si_rt  [2][SQ_N];
  logic [W+1:0]      si_rem [2][SQ_N];
  logic [W+3:0]      st     [2][SQ_N];
  logic [W+3:0]      stry   [2][SQ_N];
  logic              sge    [2][SQ_N];

  // finish
  pad_ctl_t          fc;
  logic [W-1:0]      fdist;
  logic [W-1:0]      fbase [2];
  logic [W:0]        rnd   [2];
  logic [W-1:0]      nmag  [2];
  logic [W-1:0]      mag   [2];
  logic              neg   [2];
  logic [W:0]        off   [2];
  logic signed [W+1:0] sum [2];
  logic [W-1:0]      sat   [2];
  logic [W:0]        tsx   [2];
  logic [W:0]        tam   [2];
  logic [W:0]        tneg  [2];
  logic [W-1:0]      fin   [2];

  logic              out_strobe_r;
  logic              found_r;
  logic [W-1:0]      rx_r, ry_r;

  always_comb begin
    px  = b_dist * b_adx;
    py  = b_dist * b_ady;
    sqx = b_adx * b_adx;
    sqy = b_ady * b_ady;
    s_sum = q1_r[0] + q1_r[1];
    for (int ln = 0; ln < 2; ln++) begin
      ph[ln] = p1_r[ln][W2-2:W];
      pl[ln] = p1_r[ln][W-1:0];
      hh[ln] = ph[ln] * ph[ln];
      hl[ln] = ph[ln] * pl[ln];
      ll[ln] = pl[ln] * pl[ln];
      // four times the squared scale
      nsq[ln] = ((4*W)'(hh2_r[ln]) << (W2 + 2)) + ((4*W)'(hl2_r[ln]) << (W + 3))
              + ((4*W)'(ll2_r[ln]) << 2);
    end
  end

  always_comb begin
    for (int ln = 0; ln < 2; ln++) begin
      for (int k = 0; k < DIV_N; k++) begin
        dtr[ln][k] = {drem_r[ln][k], dlo_r[ln][k][W2-1]};
        dge[ln][k] = dtr[ln][k] >= {1'b0, ds_r[k]};
      end
    end
  end

  always_comb begin
    for (int ln = 0; ln < 2; ln++) begin
      si_val[ln][0] = dq_r[ln][DIV_N];
      si_rt[ln][0]  = '0;
      si_rem[ln][0] = '0;
      for (int j = 1; j < SQ_N; j++) begin
        si_val[ln][j] = sval_r[ln][j-1];
        si_rt[ln][j]  = srt_r[ln][j-1];
        si_rem[ln][j] = srem_r[ln][j-1];
      end
      for (int j = 0; j < SQ_N; j++) begin
        st[ln][j]   = {si_rem[ln][j], si_val[ln][j][W2-1:W2-2]};
        stry[ln][j] = {2'b00, si_rt[ln][j], 2'b01};
        sge[ln][j]  = st[ln][j] >= stry[ln][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    sd1_r   <= {b_x0, b_y0, b_dist};
    c1_r    <= b_ctl;
    p1_r[0] <= px;
    p1_r[1] <= py;
    q1_r[0] <= sqx;
    q1_r[1] <= sqy;

    c2_r  <= c1_r;
    sd2_r <= sd1_r;
    s2_r  <= s_sum;
    for (int ln = 0; ln < 2; ln++) begin
      hh2_r[ln] <= hh[ln];
      hl2_r[ln] <= hl[ln];
      ll2_r[ln] <= ll[ln];
    end

    dc_r[0]  <= c2_r;
    dsd_r[0] <= sd2_r;
    ds_r[0]  <= s2_r;
    for (int ln = 0; ln < 2; ln++) begin
      drem_r[ln][0] <= {1'b0, nsq[ln][4*W-1:W2]};
      dlo_r[ln][0]  <= nsq[ln][W2-1:0];
      dq_r[ln][0]   <= '0;
    end
    for (int k = 0; k < DIV_N; k++) begin
      dc_r[k+1]  <= dc_r[k];
      dsd_r[k+1] <= dsd_r[k];
      ds_r[k+1]  <= ds_r[k];
      for (int ln = 0; ln < 2; ln++) begin
        drem_r[ln][k+1] <= dge[ln][k] ? (W2+1)'(dtr[ln][k] - {1'b0, ds_r[k]})
                                      : (W2+1)'(dtr[ln][k]);
        dlo_r[ln][k+1]  <= dlo_r[ln][k] << 1;
        dq_r[ln][k+1]   <= {dq_r[ln][k][W2-2:0], dge[ln][k]};
      end
    end

    sc_r[0]  <= dc_r[DIV_N];
    ssd_r[0] <= dsd_r[DIV_N];
    for (int j = 1; j < SQ_N; j++) begin
      sc_r[j]  <= sc_r[j-1];
      ssd_r[j] <= ssd_r[j-1];
    end
    for (int j = 0; j < SQ_N; j++) begin
      for (int ln = 0; ln < 2; ln++) begin
        sval_r[ln][j] <= si_val[ln][j] << 2;
        srt_r[ln][j]  <= {si_rt[ln][j][W-2:0], sge[ln][j]};
        srem_r[ln][j] <= sge[ln][j] ? (W+2)'(st[ln][j] - stry[ln][j]) : (W+2)'(st[ln][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int k = 0; k <= DIV_N; k++) begin
        dv_r[k] <= 1'b0;
      end
      for (int j = 0; j < SQ_N; j++) begin
        sv_r[j] <= 1'b0;
      end
      out_strobe_r <= 1'b0;
    end else begin
      v1_r    <= b_vld;
      v2_r    <= v1_r;
      dv_r[0] <= v2_r;
      for (int k = 0; k < DIV_N; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
      sv_r[0] <= dv_r[DIV_N];
      for (int j = 1; j < SQ_N; j++) begin
        sv_r[j] <= sv_r[j-1];
      end
      out_strobe_r <= sv_r[SQ_N-1];
    end
  end

  always_comb begin
    fc       = sc_r[SQ_N-1];
    fdist    = {1'b0, ssd_r[SQ_N-1][W-2:0]};
    fbase[0] = ssd_r[SQ_N-1][SIDE_W-1 -: W];
    fbase[1] = ssd_r[SQ_N-1][SIDE_W-W-1 -: W];
    neg[0]   = fc.neg_x;
    neg[1]   = fc.neg_y;
    for (int ln = 0; ln < 2; ln++) begin
      rnd[ln]  = (W+1)'(srt_r[ln][SQ_N-1]) + (W+1)'(1);
      nmag[ln] = rnd[ln][W:1];
    end
    unique case (fc.kind)
      KIND_BOTH: begin
        mag[0] = nmag[0];
        mag[1] = nmag[1];
      end
      KIND_ALONG_X: begin
        mag[0] = fdist;
        mag[1] = '0;
      end
      KIND_ALONG_Y: begin
        mag[0] = '0;
        mag[1] = fdist;
      end
      KIND_NONE: begin
        mag[0] = '0;
        mag[1] = '0;
      end
    endcase
    for (int ln = 0; ln < 2; ln++) begin
      off[ln] = neg[ln] ? ((W+1)'(0) - (W+1)'(mag[ln])) : (W+1)'(mag[ln]);
      sum[ln] = $signed({{2{fbase[ln][W-1]}}, fbase[ln]}) + $signed({off[ln][W], off[ln]});
      if (sum[ln] > MAXV) begin
        sat[ln] = MAXV[W-1:0];
      end else if (sum[ln] < MINV) begin
        sat[ln] = MINV[W-1:0];
      end else begin
        sat[ln] = sum[ln][W-1:0];
      end
      // truncation toward zero works on the magnitude
      tsx[ln]  = {sat[ln][W-1], sat[ln]};
      tam[ln]  = (sat[ln][W-1] ? ((W+1)'(0) - tsx[ln]) : tsx[ln]) & KEEP;
      tneg[ln] = (W+1)'(0) - tam[ln];
      if (fc.mode) begin
        fin[ln] = sat[ln][W-1] ? tneg[ln][W-1:0] : tam[ln][W-1:0];
      end else begin
        fin[ln] = sat[ln];
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= fc.kind != KIND_NONE;
    rx_r    <= (fc.kind == KIND_NONE) ? '0 : fin[0];
    ry_r    <= (fc.kind == KIND_NONE) ? '0 : fin[1];
  end

  assign out_strobe   = out_strobe_r;
  assign out_found    = found_r;
  assign out_result_x = rx_r;
  assign out_result_y = ry_r;

endmodule

// ===== sv/point_at_distance_along_line_core.sv =====
// Top level of the point-at-distance-along-line core.
`timescale 1ns / 1ps
// Moves from a start point a given distance toward a second point, signed fixed point.
// Input: a request is taken at a rising edge with start high and busy low. The
// front end registers it and classifies the direction, a short queue passes it to
// the back end, which is fully pipelined and never stalls, so busy stays low and
// one request can be taken every cycle.
// Output: each result is shown for one cycle with out_strobe high, in request
// order. The path from the accepting edge runs through the front end register,
// the queue, the back end's product stages, the divider (one quotient bit a stage,
// 2*COORD_WIDTH stages), the square root (one root bit a stage) and an output register.
// The receiver cannot hold results off.
// Configuration: cfg_wr_en with cfg_wr_data writes the axis snap threshold; write
// it only while no request is in flight.
// Reset: synchronous, active low; empties the pipeline and sets the threshold to 256.
module point_at_distance_along_line_core #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_toward_x,
  input  logic signed [COORD_WIDTH-1:0] in_toward_y,
  input  logic [COORD_WIDTH-2:0]        in_step_length,
  input  logic                          cfg_wr_en,
  input  logic [pad_pkg::THR_W-1:0]     cfg_wr_data,
  output logic                          out_strobe,
  output logic                          out_found,
  output logic signed [COORD_WIDTH-1:0] out_result_x,
  output logic signed [COORD_WIDTH-1:0] out_result_y
);
  import pad_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int QW = CTL_W + 5 * W - 1;

  logic          f_vld, q_ready, b_vld;
  pad_ctl_t      f_ctl, b_ctl;
  logic [W-1:0]  f_x0, f_y0, f_adx, f_ady;
  logic [W-2:0]  f_dist;
  logic [QW-1:0] q_in, q_out;

  pad_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_toward_x    (in_toward_x),
    .in_toward_y    (in_toward_y),
    .in_step_length (in_step_length),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_ready        (q_ready),
    .f_vld          (f_vld),
    .f_ctl          (f_ctl),
    .f_x0           (f_x0),
    .f_y0           (f_y0),
    .f_adx          (f_adx),
    .f_ady          (f_ady),
    .f_dist         (f_dist)
  );

  assign q_in = {f_ctl, f_x0, f_y0, f_adx, f_ady, f_dist};

  pad_queue #(.DATA_W(QW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .in_data  (q_in),
    .in_ready (q_ready),
    .out_vld  (b_vld),
    .out_data (q_out)
  );

  assign b_ctl = pad_ctl_t'(q_out[QW-1 -: CTL_W]);

  pad_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .b_vld        (b_vld),
    .b_ctl        (b_ctl),
    .b_x0         (q_out[5*W-2 -: W]),
    .b_y0         (q_out[4*W-2 -: W]),
    .b_adx        (q_out[3*W-2 -: W]),
    .b_ady        (q_out[2*W-2 -: W]),
    .b_dist       (q_out[W-2:0]),
    .out_strobe   (out_strobe),
    .out_found    (out_found),
    .out_result_x (out_result_x),
    .out_result_y (out_result_y)
  );

endmodule
